// ----- rtl/core/validated_calendar_to_unix_time_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the calendar to Unix time block
// Concurrent checks that are compiled only outside synthesis.
// ----------------------------------------------------------------------------
`ifndef VALIDATED_CALENDAR_TO_UNIX_TIME_TOP_MACROS_SVH
`define VALIDATED_CALENDAR_TO_UNIX_TIME_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define VCUT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// consequent holds on the clock after the antecedent
`define VCUT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VCUT_ASSERT(lbl, clk, rst_n, prop)
`define VCUT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/vcut_pkg.sv -----
// ----------------------------------------------------------------------------
// vcut_pkg
// Shared constants, stage types and calendar tables.
// ----------------------------------------------------------------------------
package vcut_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_EARLIEST_YEAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATEST_YEAR   = 1'd1;

    localparam logic [CFG_DATA_W-1:0] EARLIEST_YEAR_RST = 12'd2024;
    localparam logic [CFG_DATA_W-1:0] LATEST_YEAR_RST   = 12'd2069;

    localparam logic [15:0] SUPPORT_FIRST_YEAR = 16'd1970;
    localparam logic [15:0] SUPPORT_LAST_YEAR  = 16'd2399;

    localparam logic [11:0] ERA_START_HI = 12'd2000;
    localparam logic [11:0] ERA_START_LO = 12'd1600;

    localparam int unsigned DAYS_W = 18;
    localparam int unsigned TOD_W  = 17;
    localparam int unsigned SECS_W = 34;

    // era * 146097 - 719468, modulo 2^DAYS_W (era 5 and era 4)
    localparam logic [DAYS_W-1:0] DAY_OFS_HI = 18'd11017;
    localparam logic [DAYS_W-1:0] DAY_OFS_LO = 18'd127064;

    localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;

    // validated reading after the first stage
    typedef struct packed {
        logic       ok;
        logic [11:0] yy;      // year, moved back by one for Jan and Feb
        logic [3:0] mp;       // month counted from March
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_s1;

    // days from March 1 to the start of the month, (153 * mp + 2) / 5
    function automatic logic [8:0] days_before_month(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
            4'd2:                                        r = leap ? 5'd29 : 5'd28;
            default:                                     r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/vcut_check.sv -----
// ----------------------------------------------------------------------------
// vcut_check
// First pipeline stage: range checks on the reading and March-based year.
// ----------------------------------------------------------------------------
module vcut_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [vcut_pkg::CFG_DATA_W-1:0]  i_earliest_year,
    input  logic [vcut_pkg::CFG_DATA_W-1:0]  i_latest_year,
    input  logic                             i_oscillator_stopped,
    input  logic [15:0]                      i_year,
    input  logic [7:0]                       i_month,
    input  logic [7:0]                       i_day,
    input  logic [7:0]                       i_hour,
    input  logic [7:0]                       i_minute,
    input  logic [7:0]                       i_second,
    output logic                             o_valid,
    output vcut_pkg::t_s1                    o_s1
);

    logic          year_ok;
    logic          month_ok;
    logic          day_ok;
    logic          time_ok;
    logic          leap;
    logic          early_month;
    logic [4:0]    mlen;
    vcut_pkg::t_s1 n_s1;
    vcut_pkg::t_s1 r_s1;
    logic          r_valid;

    always_comb begin
        year_ok = (i_year >= {4'd0, i_earliest_year}) && (i_year <= {4'd0, i_latest_year})
               && (i_year >= vcut_pkg::SUPPORT_FIRST_YEAR)
               && (i_year <= vcut_pkg::SUPPORT_LAST_YEAR);
        // inside the supported span the only century years are 2000..2300
        leap = (i_year[1:0] == 2'd0) && (i_year != 16'd2100) && (i_year != 16'd2200)
            && (i_year != 16'd2300);
        month_ok    = (i_month >= 8'd1) && (i_month <= 8'd12);
        mlen        = vcut_pkg::month_length(i_month[3:0], leap);
        day_ok      = (i_day >= 8'd1) && (i_day <= {3'd0, mlen});
        time_ok     = (i_hour <= 8'd23) && (i_minute <= 8'd59) && (i_second <= 8'd59);
        early_month = (i_month <= 8'd2);

        n_s1.ok     = !i_oscillator_stopped && year_ok && month_ok && day_ok && time_ok;
        n_s1.yy     = i_year[11:0] - {11'd0, early_month};
        n_s1.mp     = early_month ? (i_month[3:0] + 4'd9) : (i_month[3:0] - 4'd3);
        n_s1.day    = i_day[4:0];
        n_s1.hour   = i_hour[4:0];
        n_s1.minute = i_minute[5:0];
        n_s1.second = i_second[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// ----- rtl/core/validated_calendar_to_unix_time_top.sv -----
// ----------------------------------------------------------------------------
// validated_calendar_to_unix_time_top
// Checks a decoded RTC reading and converts it to Unix seconds.
// ----------------------------------------------------------------------------
// Usage:
//   Input: pulse i_start with the reading on the field ports; the reading is
//   taken at that edge. o_busy stays low, so a reading may be given in every
//   cycle.
//   Output: o_result_valid is high for one cycle with o_unix_seconds and
//   o_status (0 ok, 1 invalid). Invalid readings report zero seconds.
//   Results leave in input order.
//   Throughput: one reading per cycle through the four register stages:
//   range check, era split, day count, seconds multiply.
//   Config: i_cfg_index 0 is the earliest accepted year, 1 the latest, each
//   written with i_cfg_valid; o_cfg_ready is always high. Write only while
//   no reading is in flight.
//   Reset: synchronous, active low; clears the pipeline valid bits and
//   loads the year window 2024..2069.
//   The receiver cannot stall: each result is present for a single cycle.
// ----------------------------------------------------------------------------
`include "validated_calendar_to_unix_time_top_macros.svh"

module validated_calendar_to_unix_time_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic                                  i_oscillator_stopped,
    input  logic [15:0]                           i_year,
    input  logic [7:0]                            i_month,
    input  logic [7:0]                            i_day,
    input  logic [7:0]                            i_hour,
    input  logic [7:0]                            i_minute,
    input  logic [7:0]                            i_second,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [vcut_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [vcut_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                  o_result_valid,
    output logic [vcut_pkg::SECS_W-1:0]           o_unix_seconds,
    output logic                                  o_status
);

    logic [vcut_pkg::CFG_DATA_W-1:0] r_earliest_year;
    logic [vcut_pkg::CFG_DATA_W-1:0] r_latest_year;

    logic          s1_valid;
    vcut_pkg::t_s1 s1;

    // stage 2
    logic        r_v2;
    logic        r_ok2;
    logic        r_era_hi;
    logic [8:0]  r_yoe;
    logic [8:0]  r_doy;
    logic [4:0]  r_hour2;
    logic [5:0]  r_min2;
    logic [5:0]  r_sec2;
    logic [8:0]  n_yoe;
    logic [8:0]  n_doy;
    logic [11:0] yoe_full;

    // stage 3
    logic                          r_v3;
    logic                          r_ok3;
    logic [vcut_pkg::DAYS_W-1:0]   r_days;
    logic [vcut_pkg::TOD_W-1:0]    r_tod;
    logic [1:0]                    cent;
    logic [vcut_pkg::DAYS_W-1:0]   doe;
    logic [vcut_pkg::DAYS_W-1:0]   n_days;
    logic [vcut_pkg::TOD_W-1:0]    n_tod;

    // output stage
    logic                          r_v4;
    logic                          r_status;
    logic [vcut_pkg::SECS_W-1:0]   r_secs;
    logic [vcut_pkg::SECS_W-1:0]   n_secs;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earliest_year <= vcut_pkg::EARLIEST_YEAR_RST;
            r_latest_year   <= vcut_pkg::LATEST_YEAR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vcut_pkg::REG_EARLIEST_YEAR: r_earliest_year <= i_cfg_data;
                vcut_pkg::REG_LATEST_YEAR:   r_latest_year   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vcut_check u_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_start),
        .i_earliest_year      (r_earliest_year),
        .i_latest_year        (r_latest_year),
        .i_oscillator_stopped (i_oscillator_stopped),
        .i_year               (i_year),
        .i_month              (i_month),
        .i_day                (i_day),
        .i_hour               (i_hour),
        .i_minute             (i_minute),
        .i_second             (i_second),
        .o_valid              (s1_valid),
        .o_s1                 (s1)
    );

    // stage 2: split into 400-year era and year of era, day of year from March
    always_comb begin
        yoe_full = (s1.yy >= vcut_pkg::ERA_START_HI) ? (s1.yy - vcut_pkg::ERA_START_HI)
                                                      : (s1.yy - vcut_pkg::ERA_START_LO);
        n_yoe    = yoe_full[8:0];
        n_doy    = vcut_pkg::days_before_month(s1.mp) + {4'd0, s1.day} - 9'd1;
    end

    always_ff @(posedge i_clk) begin
        r_ok2    <= s1.ok;
        r_era_hi <= (s1.yy >= vcut_pkg::ERA_START_HI);
        r_yoe    <= n_yoe;
        r_doy    <= n_doy;
        r_hour2  <= s1.hour;
        r_min2   <= s1.minute;
        r_sec2   <= s1.second;
    end

    // stage 3: day count since epoch and time of day
    always_comb begin
        if (r_yoe >= 9'd300) begin
            cent = 2'd3;
        end else if (r_yoe >= 9'd200) begin
            cent = 2'd2;
        end else if (r_yoe >= 9'd100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
        doe = 18'(r_yoe) * 18'd365 + 18'(r_yoe[8:2]) - 18'(cent) + 18'(r_doy);
        // wraps modulo 2^18; the true count is non-negative for valid readings
        n_days = doe + (r_era_hi ? vcut_pkg::DAY_OFS_HI : vcut_pkg::DAY_OFS_LO);
        n_tod  = 17'(r_hour2) * 17'd3600 + 17'(r_min2) * 17'd60 + 17'(r_sec2);
    end

    always_ff @(posedge i_clk) begin
        r_ok3  <= r_ok2;
        r_days <= n_days;
        r_tod  <= n_tod;
    end

    // stage 4: seconds
    always_comb begin
        n_secs = 34'(r_days) * 34'(vcut_pkg::SECONDS_PER_DAY) + 34'(r_tod);
    end

    always_ff @(posedge i_clk) begin
        r_status <= !r_ok3;
        r_secs   <= r_ok3 ? n_secs : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= s1_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_result_valid = r_v4;
    assign o_unix_seconds = r_secs;
    assign o_status       = r_status;

    `VCUT_ASSERT(a_latency, i_clk, i_rst_n, i_start |-> ##4 o_result_valid)
    `VCUT_ASSERT(a_stopped_invalid, i_clk, i_rst_n,
        (i_start && i_oscillator_stopped) |-> ##4 (o_result_valid && o_status))
    `VCUT_ASSERT(a_invalid_zero, i_clk, i_rst_n,
        (o_result_valid && o_status) |-> (o_unix_seconds == '0))
    `VCUT_ASSERT(a_ok_in_span, i_clk, i_rst_n,
        (o_result_valid && !o_status) |-> (o_unix_seconds < 34'd13569465600))
    `VCUT_ASSERT_NEXT(a_cfg_earliest, i_clk, i_rst_n,
        i_cfg_valid && (i_cfg_index == vcut_pkg::REG_EARLIEST_YEAR),
        r_earliest_year == $past(i_cfg_data))

endmodule

// ----- tb/sv/validated_calendar_to_unix_time_top_tb.sv -----
// ----------------------------------------------------------------------------
// validated_calendar_to_unix_time_top_tb
// Self-checking bench for the RTC reading to Unix seconds converter. A
// directed table covers window edges, leap days, bad fields and a stopped
// oscillator. Random readings follow under several year windows. Every
// result is checked in order, field by field, against the table or predictor.
// ----------------------------------------------------------------------------
module validated_calendar_to_unix_time_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vcut_pkg::*;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_INVALID = 1'b1;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASES         = 7;
    localparam int unsigned ITEMS_PER_PHASE = 90;
    localparam int unsigned N_DIR          = 28;

    typedef struct packed {
        logic        osc;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } reading_t;

    typedef struct packed {
        logic [SECS_W-1:0] secs;
        logic              status;
    } epoch_t;

    typedef enum logic {ROW_CFG, ROW_READ} row_kind_e;

    // config rows use first/last, reading rows the calendar fields
    typedef struct packed {
        row_kind_e         kind;
        logic [11:0]       first;
        logic [11:0]       last;
        logic              osc;
        logic [15:0]       year;
        logic [7:0]        month;
        logic [7:0]        day;
        logic [7:0]        hour;
        logic [7:0]        minute;
        logic [7:0]        second;
        logic              fixed;
        logic [SECS_W-1:0] secs;
        logic              status;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic                  i_oscillator_stopped;
    logic [15:0]           i_year;
    logic [7:0]            i_month;
    logic [7:0]            i_day;
    logic [7:0]            i_hour;
    logic [7:0]            i_minute;
    logic [7:0]            i_second;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_result_valid;
    logic [SECS_W-1:0]     o_unix_seconds;
    logic                  o_status;

    logic [11:0] win_first;
    logic [11:0] win_last;
    bit          gaps_on;
    int unsigned fail_count;
    int unsigned quiet_cycles;
    epoch_t      pending_times[$];

    dir_row_t dir_rows [N_DIR] = '{
        // reset window 2024..2069
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd1704067200, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2069, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59,
          1'b1, 34'd3155759999, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2023, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2070, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b1, 16'd2030, 8'd6, 8'd15, 8'd12, 8'd30, 8'd30,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd2, 8'd29, 8'd12, 8'd0, 8'd0,
          1'b0, 34'd0, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2025, 8'd2, 8'd29, 8'd12, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd4, 8'd31, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd13, 8'd10, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd1, 8'd32, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd6, 8'd1, 8'd24, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd6, 8'd1, 8'd0, 8'd60, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd6, 8'd1, 8'd0, 8'd0, 8'd60,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2024, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0,
          1'b0, 34'd0, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2031, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59,
          1'b0, 34'd0, STAT_OK},
        // full supported span
        '{ROW_CFG, 12'd1970, 12'd2399, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b0, 34'd0, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd1970, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2399, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59,
          1'b1, 34'd13569465599, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2000, 8'd2, 8'd29, 8'd6, 8'd7, 8'd8,
          1'b0, 34'd0, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2100, 8'd2, 8'd29, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        // window wider than the supported span
        '{ROW_CFG, 12'd0, 12'd4095, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b0, 34'd0, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd1969, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59,
          1'b1, 34'd0, STAT_INVALID},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2400, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0,
          1'b1, 34'd0, STAT_INVALID},
        // empty window
        '{ROW_CFG, 12'd2100, 12'd2000, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b0, 34'd0, STAT_OK},
        '{ROW_READ, 12'd0, 12'd0, 1'b0, 16'd2050, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6,
          1'b1, 34'd0, STAT_INVALID}
    };

    validated_calendar_to_unix_time_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (i_start),
        .o_busy               (o_busy),
        .i_oscillator_stopped (i_oscillator_stopped),
        .i_year               (i_year),
        .i_month              (i_month),
        .i_day                (i_day),
        .i_hour               (i_hour),
        .i_minute             (i_minute),
        .i_second             (i_second),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_result_valid       (o_result_valid),
        .o_unix_seconds       (o_unix_seconds),
        .o_status             (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_len(int unsigned y, int unsigned m);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // days-from-civil conversion, March-based years in 400-year eras
    function automatic epoch_t calendar_to_epoch(reading_t r);
        epoch_t          res;
        bit              good;
        longint unsigned yy, era, yoe, mp, doy, doe, days;
        res.secs   = '0;
        res.status = STAT_INVALID;
        good = !r.osc && r.year >= win_first && r.year <= win_last
            && r.year >= SUPPORT_FIRST_YEAR && r.year <= SUPPORT_LAST_YEAR
            && r.month >= 1 && r.month <= 12
            && r.hour <= 23 && r.minute <= 59 && r.second <= 59;
        if (good) begin
            good = r.day >= 1 && r.day <= month_len(r.year, r.month);
        end
        if (!good) begin
            return res;
        end
        yy   = 64'(r.year) - ((r.month <= 2) ? 64'd1 : 64'd0);
        era  = yy / 400;
        yoe  = yy - era * 400;
        mp   = (r.month > 2) ? 64'(r.month) - 64'd3 : 64'(r.month) + 64'd9;
        doy  = (153 * mp + 2) / 5 + 64'(r.day) - 64'd1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        res.secs   = SECS_W'(days * 86400 + 64'(r.hour) * 3600 + 64'(r.minute) * 60
                             + 64'(r.second));
        res.status = STAT_OK;
        return res;
    endfunction

    // mostly well-formed readings in the window, the span or at their edges, the rest broken or noise
    function automatic reading_t random_reading();
        reading_t    r;
        int unsigned pick;
        int unsigned len;
        logic [63:0] noise;
        r.osc    = ($urandom_range(0, 15) == 0);
        pick     = $urandom_range(0, 9);
        if (pick < 5) begin
            r.year = 16'($urandom_range(win_first, win_last));
        end else if (pick < 8) begin
            r.year = 16'($urandom_range(SUPPORT_FIRST_YEAR, SUPPORT_LAST_YEAR));
        end else begin
            case ($urandom_range(0, 7))
                0:       r.year = {4'd0, win_first} - 16'd1;
                1:       r.year = {4'd0, win_first};
                2:       r.year = {4'd0, win_last};
                3:       r.year = {4'd0, win_last} + 16'd1;
                4:       r.year = SUPPORT_FIRST_YEAR - 16'd1;
                5:       r.year = SUPPORT_FIRST_YEAR;
                6:       r.year = SUPPORT_LAST_YEAR;
                default: r.year = SUPPORT_LAST_YEAR + 16'd1;
            endcase
        end
        r.month  = 8'($urandom_range(1, 12));
        len      = month_len(r.year, r.month);
        r.day    = 8'(($urandom_range(0, 5) == 0) ? len : $urandom_range(1, len));
        r.hour   = 8'(($urandom_range(0, 7) == 0) ? 23 : $urandom_range(0, 23));
        r.minute = 8'(($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59));
        r.second = 8'(($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59));
        pick     = $urandom_range(0, 99);
        if (pick >= 85) begin
            noise  = {$urandom, $urandom};
            r      = noise[$bits(reading_t)-1:0];
            r.year = 16'($urandom_range(0, 65535));
            r.osc  = 1'($urandom_range(0, 1));
        end else if (pick >= 70) begin
            case ($urandom_range(0, 4))
                0:       r.month  = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(13, 255));
                1:       r.day    = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(len + 1, 255));
                2:       r.hour   = 8'($urandom_range(24, 255));
                3:       r.minute = 8'($urandom_range(60, 255));
                default: r.second = 8'($urandom_range(60, 255));
            endcase
        end
        return r;
    endfunction

    // entered and left just after a falling edge
    task automatic send_reading(reading_t r, bit has_fixed, epoch_t fixed_res);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_oscillator_stopped = r.osc;
        i_year   = r.year;
        i_month  = r.month;
        i_day    = r.day;
        i_hour   = r.hour;
        i_minute = r.minute;
        i_second = r.second;
        i_start  = 1'b1;
        do @(posedge i_clk); while (o_busy);
        pending_times.push_back(has_fixed ? fixed_res : calendar_to_epoch(r));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_start = 1'b0;
        while (pending_times.size() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_EARLIEST_YEAR) begin
            win_first = data;
        end else begin
            win_last = data;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_window(logic [11:0] first, logic [11:0] last);
        wait_drained();
        cfg_write(REG_EARLIEST_YEAR, first);
        cfg_write(REG_LATEST_YEAR, last);
    endtask

    // result checker
    always @(posedge i_clk) begin
        epoch_t want;
        if (i_rst_n && o_result_valid) begin
            if (pending_times.size() == 0) begin
                $display("%0t: unexpected result secs=%0d status=%0b",
                         $time, o_unix_seconds, o_status);
                fail_count++;
            end else begin
                want = pending_times.pop_front();
                if (o_unix_seconds !== want.secs) begin
                    $display("%0t: unix_seconds expected %0d actual %0d",
                             $time, want.secs, o_unix_seconds);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, want.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    // ends the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_result_valid
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reading_t    r;
        epoch_t      fixed_res;
        logic [11:0] ph_first [PHASES];
        logic [11:0] ph_last  [PHASES];
        i_rst_n              = 1'b0;
        i_start              = 1'b0;
        i_oscillator_stopped = 1'b0;
        i_year               = '0;
        i_month              = '0;
        i_day                = '0;
        i_hour               = '0;
        i_minute             = '0;
        i_second             = '0;
        i_cfg_valid          = 1'b0;
        i_cfg_index          = REG_EARLIEST_YEAR;
        i_cfg_data           = '0;
        win_first            = EARLIEST_YEAR_RST;
        win_last             = LATEST_YEAR_RST;
        gaps_on              = 1'b1;
        fail_count           = 0;
        quiet_cycles         = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                set_window(dir_rows[k].first, dir_rows[k].last);
            end else begin
                r.osc    = dir_rows[k].osc;
                r.year   = dir_rows[k].year;
                r.month  = dir_rows[k].month;
                r.day    = dir_rows[k].day;
                r.hour   = dir_rows[k].hour;
                r.minute = dir_rows[k].minute;
                r.second = dir_rows[k].second;
                fixed_res.secs   = dir_rows[k].secs;
                fixed_res.status = dir_rows[k].status;
                send_reading(r, dir_rows[k].fixed, fixed_res);
            end
        end

        ph_first[0] = EARLIEST_YEAR_RST;  ph_last[0] = LATEST_YEAR_RST;
        ph_first[1] = 12'd0;              ph_last[1] = 12'd4095;
        ph_first[2] = 12'd2399;           ph_last[2] = 12'd1970;
        ph_first[3] = 12'd2000;           ph_last[3] = 12'd2000;
        ph_first[4] = 12'($urandom_range(1970, 2399));
        ph_last[4]  = 12'($urandom_range(1970, 2399));
        ph_first[5] = 12'($urandom_range(1970, 2399));
        ph_last[5]  = 12'($urandom_range(ph_first[5], 2399));
        ph_first[6] = 12'd1970;           ph_last[6] = 12'd2399;

        fixed_res = '0;
        for (int p = 0; p < PHASES; p++) begin
            set_window(ph_first[p], ph_last[p]);
            // no random gaps between transfers in the last phase
            gaps_on = (p != PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_reading(random_reading(), 1'b0, fixed_res);
                if (gaps_on && $urandom_range(0, 59) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
